>>> src/lct_pkg.sv
// Shared types, constants and pair arithmetic for the LIS count tracker.
`default_nettype none
package lct_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int VALUE_W     = 10;
  localparam int LEVELS      = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int NODE_W      = LEVELS + 1;
  localparam int LEN_W       = 11;
  localparam int CNT_W       = 32;
  localparam int EPOCH_W     = 4;
  localparam int WORD_W      = EPOCH_W + LEN_W + CNT_W;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] ways;
  } pair_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               start_new;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] elem_len;
    logic [CNT_W-1:0] elem_ways;
    logic [LEN_W-1:0] best_len;
    logic [CNT_W-1:0] best_count;
  } out_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic q_step;
    logic load_leaf;
    logic leaf_wr;
    logic up_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_last;
    logic at_root;
    logic epoch_wrap;
  } stat_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic pair_t merge(input pair_t a, input pair_t b);
    pair_t r;
    if (a.len > b.len) begin
      r = a;
    end else if (a.len < b.len) begin
      r = b;
    end else begin
      r.len  = a.len;
      r.ways = sat_add(a.ways, b.ways);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/lct_ctrl.sv
// Sequencer for the LIS count tracker: clear pass, prefix query, leaf-to-root update.
`default_nettype none
module lct_ctrl
  import lct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_start_new,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QUERY = 3'd2;
  localparam logic [2:0] ST_QLAST = 3'd3;
  localparam logic [2:0] ST_ELEM  = 3'd4;
  localparam logic [2:0] ST_LEAF  = 3'd5;
  localparam logic [2:0] ST_UP    = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state, state_next;
  logic       held, held_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    held_next      = held;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = held ? ST_QUERY : ST_IDLE;
          held_next  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_start_new && stat.epoch_wrap) begin
            state_next = ST_CLEAR;
            held_next  = 1'b1;
          end else begin
            state_next = ST_QUERY;
          end
        end
      end
      ST_QUERY: begin
        cmd.q_step = 1'b1;
        if (stat.q_last) state_next = ST_QLAST;
      end
      ST_QLAST: begin
        state_next = ST_ELEM;
      end
      ST_ELEM: begin
        cmd.load_leaf = 1'b1;
        state_next    = ST_LEAF;
      end
      ST_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_next  = ST_UP;
      end
      ST_UP: begin
        cmd.up_step = 1'b1;
        if (stat.at_root) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> src/lct_path.sv
// Datapath for the LIS count tracker: node memory, query accumulator, path update.
`default_nettype none
module lct_path
  import lct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire in_t  in_data,
  input  wire cmd_t cmd,
  output stat_t     stat,
  output out_t      out_data
);

  logic [WORD_W-1:0]  mem [2**NODE_W];
  logic [WORD_W-1:0]  rd_word;
  logic [NODE_W-1:0]  rd_addr;
  logic               wr_en;
  logic [NODE_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_word;

  logic [EPOCH_W-1:0] epoch;
  logic [NODE_W-1:0]  clr_addr;
  logic [LEVELS-1:0]  leaf;
  logic [NODE_W-1:0]  pos;
  logic               q_take;
  pair_t              acc, cur, elem;

  logic [31:0]        vx;
  logic [LEVELS-1:0]  leaf_in;
  logic [NODE_W-1:0]  leaf_addr;
  pair_t              rd_pair, elem_new, leaf_new, up_new;

  // clamp the incoming value into the tree's range
  always_comb begin
    vx = 32'(in_data.value);
    if (vx >= 32'(VALUE_RANGE)) vx = 32'(VALUE_RANGE - 1);
    leaf_in = vx[LEVELS-1:0];
  end

  assign leaf_addr = {1'b1, leaf};

  // stale epoch reads as the cleared pair
  always_comb begin
    if (rd_word[WORD_W-1 -: EPOCH_W] == epoch) rd_pair = rd_word[LEN_W+CNT_W-1:0];
    else rd_pair = '0;
  end

  always_comb begin
    if (acc.len != '0) begin
      elem_new.len  = acc.len + LEN_W'(1);
      elem_new.ways = acc.ways;
    end else begin
      elem_new.len  = LEN_W'(1);
      elem_new.ways = CNT_W'(1);
    end
  end

  always_comb begin
    if (rd_pair.len == elem.len) begin
      leaf_new.len  = elem.len;
      leaf_new.ways = sat_add(rd_pair.ways, elem.ways);
    end else begin
      leaf_new = elem;
    end
  end

  assign up_new  = merge(cur, rd_pair);
  assign rd_addr = cmd.load_leaf ? leaf_addr : (pos ^ NODE_W'(1));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_word = {epoch, up_new};
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_word = '0;
    end else if (cmd.leaf_wr) begin
      wr_en   = 1'b1;
      wr_word = {epoch, leaf_new};
    end else if (cmd.up_step) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    rd_word <= mem[rd_addr];
  end

  assign stat.clr_last   = &clr_addr;
  assign stat.q_last     = ((pos >> 1) == NODE_W'(1));
  assign stat.at_root    = (pos == NODE_W'(1));
  assign stat.epoch_wrap = &epoch;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= '0;
      clr_addr <= '0;
      q_take   <= 1'b0;
    end else begin
      q_take <= cmd.q_step & pos[0];
      if (cmd.clr_step) clr_addr <= clr_addr + NODE_W'(1);
      if (cmd.accept && in_data.start_new) epoch <= epoch + EPOCH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      leaf <= leaf_in;
      pos  <= {1'b1, leaf_in};
      acc  <= '0;
    end else if (q_take) begin
      acc <= merge(acc, rd_pair);
    end
    if (cmd.q_step) pos <= pos >> 1;
    if (cmd.load_leaf) begin
      elem <= elem_new;
      pos  <= leaf_addr;
    end
    if (cmd.leaf_wr) begin
      cur <= leaf_new;
      pos <= pos >> 1;
    end
    if (cmd.up_step) begin
      cur <= up_new;
      pos <= pos >> 1;
    end
    if (cmd.load_out) begin
      out_data.elem_len   <= elem.len;
      out_data.elem_ways  <= elem.ways;
      out_data.best_len   <= cur.len;
      out_data.best_count <= cur.ways;
    end
  end

endmodule
`default_nettype wire

>>> src/lis_count_tracker.sv
// Top level of the LIS count tracker: sequencer plus tree datapath.
`default_nettype none
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | to block  | in_valid/in_stall  | in_t  {value, start_new}
//  out     | from block| out_valid/out_stall| out_t {elem_len, elem_ways,
//          |           |                    |        best_len, best_count}
//
//  For each element: one sibling read per tree level for the prefix query, then
//  one sibling read and parent write per level for the update, all through the
//  single read port of the node memory.
//  After reset a clearing pass sweeps all 2*2^log2(VALUE_RANGE) nodes, 2048 in
//  all, before the first transaction is taken. start_new bumps an epoch tag
//  instead of clearing; every 16th start_new the epoch wraps and the same pass
//  runs again before that element is processed.
//  A finished result waits in the output register; the next input transaction
//  is taken while it is stalled, and the block stalls only at its own end.
//
module lis_count_tracker
  import lct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  cmd_t  cmd;
  stat_t stat;

  lct_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_start_new (in_data.start_new),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  lct_path u_path (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> bench/tb_lis_count_tracker.sv
`timescale 1ns / 100ps
// Self-checking bench for lis_count_tracker: directed table, then random sequences.
module tb_lis_count_tracker;
  import lct_pkg::*;

  // Leaf count of the shadow tree: next power of two at or above the value range.
  localparam int LEAF_N       = 1 << $clog2(VALUE_RANGE);
  localparam int RAND_ITEMS   = 1650;
  // Long receiver hold-off: far longer than one element, so the block backs up.
  localparam int HOLD_CYCLES  = 250;
  // Cycles allowed after the last result.
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 18;

  // Shadow tree node: best length under the node and how many chains reach it.
  // Length is kept wide here and only cut to LEN_W on the way out.
  typedef struct packed {
    logic [31:0]      len;
    logic [CNT_W-1:0] ways;
  } chain_t;

  // One row of the directed table; typed rows carry an expected transaction
  // read straight off the behavior, the others are left to the predictor.
  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } row_t;

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Predicted result transactions, oldest first.
  out_t   lis_pending [$];
  chain_t shadow_tree [2*LEAF_N];

  int unsigned fed_count;
  int unsigned mismatch_count;
  bit          no_idle;
  bit          hold_req;
  int unsigned hold_left;

  lis_count_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Predictor: same tree, same order of updates, counts saturate at all ones.
  // ---------------------------------------------------------------------------
  function automatic logic [CNT_W-1:0] ways_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Longer chain wins; on a tie the counts add.
  function automatic chain_t longer_of(input chain_t a, input chain_t b);
    chain_t r;
    if (a.len > b.len) begin
      r = a;
    end else if (a.len < b.len) begin
      r = b;
    end else begin
      r.len  = a.len;
      r.ways = ways_add(a.ways, b.ways);
    end
    return r;
  endfunction

  function automatic void shadow_clear();
    for (int i = 0; i < 2*LEAF_N; i++) shadow_tree[i] = '0;
  endfunction

  // Advances the shadow tree by one element and returns the report it causes.
  function automatic out_t lis_predict(input in_t item);
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    chain_t      acc;
    chain_t      own;
    out_t        rep;
    // start_new wipes the tree first; the element then opens the new sequence
    if (item.start_new) shadow_clear();
    v = item.value;
    if (v >= VALUE_RANGE) v = VALUE_RANGE - 1;
    // best chain over all strictly smaller values, bottom-up half-open walk
    acc = '0;
    lo  = LEAF_N;
    hi  = LEAF_N + v;
    while (lo < hi) begin
      if (lo[0]) begin
        acc = longer_of(acc, shadow_tree[lo]);
        lo++;
      end
      if (hi[0]) begin
        hi--;
        acc = longer_of(acc, shadow_tree[hi]);
      end
      lo >>= 1;
      hi >>= 1;
    end
    own.len  = 1;
    own.ways = 1;
    if (acc.len >= 1) begin
      own.len  = acc.len + 1;
      own.ways = acc.ways;
    end
    // leaf: same length adds ways, any other length replaces the leaf
    pos = LEAF_N + v;
    if (shadow_tree[pos].len == own.len) begin
      shadow_tree[pos].ways = ways_add(shadow_tree[pos].ways, own.ways);
    end else begin
      shadow_tree[pos] = own;
    end
    for (pos = pos >> 1; pos >= 1; pos >>= 1) begin
      shadow_tree[pos] = longer_of(shadow_tree[2*pos], shadow_tree[2*pos+1]);
    end
    rep.elem_len   = own.len[LEN_W-1:0];
    rep.elem_ways  = own.ways;
    rep.best_len   = shadow_tree[1].len[LEN_W-1:0];
    rep.best_count = shadow_tree[1].ways;
    return rep;
  endfunction

  function automatic row_t mk_row(input int unsigned value, input bit start,
                                  input bit typed, input int unsigned el,
                                  input longint unsigned ew, input int unsigned bl,
                                  input longint unsigned bc);
    row_t r;
    r.item.value      = value[VALUE_W-1:0];
    r.item.start_new  = start;
    r.typed           = typed;
    r.want.elem_len   = el[LEN_W-1:0];
    r.want.elem_ways  = ew[CNT_W-1:0];
    r.want.best_len   = bl[LEN_W-1:0];
    r.want.best_count = bc[CNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random idle cycles, then hold the transaction until accepted.
  // in_valid stays high from one transaction to the next when no idle falls.
  // ---------------------------------------------------------------------------
  task automatic feed(input int unsigned value, input bit start, input bit typed,
                      input out_t typed_want);
    in_t  item;
    out_t want;
    item.value     = value[VALUE_W-1:0];
    item.start_new = start;
    want = lis_predict(item);
    if (typed) want = typed_want;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    lis_pending.push_back(want);
    fed_count++;
  endtask

  // Sender pause: nothing new goes in until every predicted result is back.
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (lis_pending.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, plus one long hold-off counted here on request.
  // ---------------------------------------------------------------------------
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Result checker: every accepted result transaction against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (lis_pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result len=%0d ways=%0d best=%0d count=%0d", $realtime,
                   out_data.elem_len, out_data.elem_ways, out_data.best_len,
                   out_data.best_count);
      end else begin
        want = lis_pending.pop_front();
        if (out_data.elem_len !== want.elem_len || out_data.elem_ways !== want.elem_ways ||
            out_data.best_len !== want.best_len || out_data.best_count !== want.best_count)
        begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp len=%0d ways=%0d best=%0d count=%0d", $realtime,
                     want.elem_len, want.elem_ways, want.best_len, want.best_count);
            $display("%0t:          got len=%0d ways=%0d best=%0d count=%0d", $realtime,
                     out_data.elem_len, out_data.elem_ways, out_data.best_len,
                     out_data.best_count);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t        rows [$];
    int unsigned seg_len;
    int unsigned base;
    int unsigned v;
    int unsigned kind;
    int unsigned span;
    bit          run_done;
    bit          hold_done;
    bit          pause_done;

    fed_count      = 0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    run_done       = 1'b0;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    shadow_clear();

    // first element after reset, then value extremes
    rows.push_back(mk_row(0,     0, 1, 1, 1, 1, 1));
    rows.push_back(mk_row(1023,  0, 1, 2, 1, 2, 1));
    // same top value again: leaf length ties, root count doubles
    rows.push_back(mk_row(1023,  0, 1, 2, 1, 2, 2));
    // clear and element in one transaction
    rows.push_back(mk_row(0,     1, 1, 1, 1, 1, 1));
    // equal value never extends a chain (strictly increasing)
    rows.push_back(mk_row(0,     0, 1, 1, 1, 1, 2));
    rows.push_back(mk_row(1023,  1, 1, 1, 1, 1, 1));
    // descending elements stand alone, then 1 extends the chain ending at 0
    rows.push_back(mk_row(1022,  0, 1, 1, 1, 1, 2));
    rows.push_back(mk_row(0,     0, 1, 1, 1, 1, 3));
    rows.push_back(mk_row(1,     0, 1, 2, 1, 2, 1));
    // bit patterns and tree-boundary values, left to the predictor
    rows.push_back(mk_row(10'h155, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h2AA, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h3FF, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h000, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h200, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h100, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h300, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h180, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h3FE, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h001, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h003, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h002, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h005, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h004, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(10'h3FF, 0, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // block runs its clearing sweep first; feed() just waits on in_stall
    foreach (rows[i]) feed(rows[i].item.value, rows[i].item.start_new, rows[i].typed,
                           rows[i].want);
    drain_wait();

    // random part, built from whole segments
    while (fed_count < rows.size() + RAND_ITEMS) begin
      // receiver hold-off while we keep offering: block fills, input stalls
      if (!hold_done && fed_count >= 100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      no_idle = (fed_count >= 150 && fed_count < 300);
      if (!pause_done && fed_count >= 1500) begin
        drain_wait();
        pause_done = 1'b1;
      end

      kind = $urandom_range(0, 9);
      if (!run_done && fed_count >= 300) begin
        // full ascending run, reaches the longest possible chain; random
        // repeats add ways on a tied leaf
        run_done = 1'b1;
        for (v = 0; v < VALUE_RANGE; v++) begin
          feed(v, v == 0, 0, '0);
          if ($urandom_range(0, 19) == 0) feed(v, 0, 0, '0);
        end
      end else if (kind <= 3) begin
        // fresh random sequence, wide values or a narrow band for many ties
        seg_len = $urandom_range(8, 60);
        span    = $urandom_range(0, 1) ? (1 << VALUE_W) - 1 : $urandom_range(3, 15);
        base    = $urandom_range(0, (1 << VALUE_W) - 1 - span);
        for (int k = 0; k < seg_len; k++)
          feed(base + $urandom_range(0, span), k == 0, 0, '0);
      end else if (kind <= 5) begin
        // pairs (b+1, b), (b+3, b+2), ...: each pair doubles the count, so
        // counts hit saturation after 32 pairs
        seg_len = $urandom_range(34, 40);
        base    = $urandom_range(0, (1 << VALUE_W) - 2 * seg_len - 1);
        for (int k = 0; k < seg_len; k++) begin
          feed(base + 2 * k + 1, k == 0, 0, '0);
          feed(base + 2 * k,     0,      0, '0);
        end
        // saturated leaf adding to itself
        repeat ($urandom_range(0, 3)) feed(base + 2 * seg_len - 2, 0, 0, '0);
      end else if (kind <= 7) begin
        // slowly rising sequence with repeats
        seg_len = $urandom_range(20, 60);
        v       = $urandom_range(0, 200);
        for (int k = 0; k < seg_len; k++) begin
          feed(v, k == 0, 0, '0);
          v = v + $urandom_range(0, 3);
          if (v > (1 << VALUE_W) - 1) v = (1 << VALUE_W) - 1;
        end
      end else begin
        // noise: no sequence structure, stray clears
        seg_len = $urandom_range(10, 40);
        for (int k = 0; k < seg_len; k++)
          feed($urandom_range(0, (1 << VALUE_W) - 1), $urandom_range(0, 5) == 0, 0, '0);
      end
    end
    no_idle = 1'b0;

    drain_wait();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && lis_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
